// ===== hw/rtl/tkee_pkg.sv =====
// Shared types for the terminal key event encoder.
// Holds the byte sequence descriptor and the queue status group.
// No dependencies.
package tkee_pkg;

   // Longest sequence is ESC [ 2 4 ; m ~, seven bytes.
   localparam int SeqMax   = 7;
   localparam int LenWidth = 3;

   typedef logic [7:0] byte_type;

   typedef struct packed {
      logic [SeqMax-1:0][7:0] seq_bytes;
      logic [LenWidth-1:0]    len;
   } seq_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

endpackage

// ===== hw/rtl/tkee_if.sv =====
// Valid/ready channel interfaces for the terminal key event encoder.
// tkee_req_if carries keyboard events, tkee_rsp_if carries output bytes.
// No dependencies.
interface tkee_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  mode;
   logic [8:0]  key_code;
   logic [20:0] codepoint;
   logic [2:0]  modifiers;

   modport source (output valid, output mode, output key_code, output codepoint,
                   output modifiers, input ready);
   modport sink (input valid, input mode, input key_code, input codepoint,
                 input modifiers, output ready);
endinterface

interface tkee_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       last;

   modport source (output valid, output out_byte, output last, input ready);
   modport sink (input valid, input out_byte, input last, output ready);
endinterface

// ===== hw/rtl/terminal_key_event_encoder.sv =====
// Top level of the terminal key event encoder.
// Depends on tkee_pkg, tkee_if, tkee_front, tkee_queue and tkee_back.
//
// Usage:
//   req_ch carries one keyboard event per word (mode, key_code, codepoint,
//   modifiers). rsp_ch returns the event's terminal byte sequence, one byte
//   per word, with last set on the final byte. Events that map to nothing
//   (key up, unknown mode, unmapped keys, invalid codepoints) are accepted
//   and produce no words.
//   An accepted event passes through the descriptor queue and the current
//   sequence register before its first byte reaches the output register.
//   Throughput: the output register sends one byte per cycle while the
//   receiver takes them, with no gaps inside or between sequences while the
//   queue holds the next. Events give 1 to 7 bytes. The front end takes an
//   event every cycle while the descriptor queue (QueueDepth entries) has room.
//   Reset empties the queue and the output register; req_ch.ready is high in
//   the cycle after reset. When the receiver holds rsp_ch.ready low, the
//   current byte stays put, the queue fills, and req_ch.ready then drops.
module terminal_key_event_encoder #(
   parameter int QueueDepth = 4
) (
   input  logic       clock,
   input  logic       reset,
   tkee_req_if.sink   req_ch,
   tkee_rsp_if.source rsp_ch
);

   tkee_pkg::queue_status_type q_status;
   tkee_pkg::seq_type          push_data;
   tkee_pkg::seq_type          pop_data;
   logic                       push;
   logic                       pop;

   tkee_front u_front (
      .req      (req_ch),
      .q_status (q_status),
      .push     (push),
      .seq      (push_data)
   );

   tkee_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .status    (q_status)
   );

   tkee_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_status (q_status),
      .q_data   (pop_data),
      .pop      (pop),
      .rsp      (rsp_ch)
   );

endmodule

// ===== hw/rtl/tkee_front.sv =====
// Front end: accepts keyboard events and classifies them into byte sequences.
// Depends on tkee_pkg and tkee_req_if; feeds tkee_queue.
module tkee_front (
   tkee_req_if.sink                 req,
   input  tkee_pkg::queue_status_type q_status,
   output logic                     push,
   output tkee_pkg::seq_type        seq
);

   localparam logic [1:0]  ModeChar    = 2'd0;
   localparam logic [1:0]  ModeKeyDown = 2'd1;

   localparam logic [8:0]  KeyEscape   = 9'd256;
   localparam logic [8:0]  KeyEnter    = 9'd257;
   localparam logic [8:0]  KeyTab      = 9'd258;
   localparam logic [8:0]  KeyBackspc  = 9'd259;
   localparam logic [8:0]  KeyInsert   = 9'd260;
   localparam logic [8:0]  KeyDelete   = 9'd261;
   localparam logic [8:0]  KeyRight    = 9'd262;
   localparam logic [8:0]  KeyLeft     = 9'd263;
   localparam logic [8:0]  KeyDown     = 9'd264;
   localparam logic [8:0]  KeyUp       = 9'd265;
   localparam logic [8:0]  KeyPageUp   = 9'd266;
   localparam logic [8:0]  KeyPageDown = 9'd267;
   localparam logic [8:0]  KeyHome     = 9'd268;
   localparam logic [8:0]  KeyEnd      = 9'd269;
   localparam logic [8:0]  KeyF1       = 9'd290;
   localparam logic [8:0]  KeyF2       = 9'd291;
   localparam logic [8:0]  KeyF3       = 9'd292;
   localparam logic [8:0]  KeyF4       = 9'd293;
   localparam logic [8:0]  KeyF5       = 9'd294;
   localparam logic [8:0]  KeyF6       = 9'd295;
   localparam logic [8:0]  KeyF7       = 9'd296;
   localparam logic [8:0]  KeyF8       = 9'd297;
   localparam logic [8:0]  KeyF9       = 9'd298;
   localparam logic [8:0]  KeyF10      = 9'd299;
   localparam logic [8:0]  KeyF11      = 9'd300;
   localparam logic [8:0]  KeyF12      = 9'd301;
   localparam logic [8:0]  KeyKpEnter  = 9'd335;
   localparam logic [8:0]  KeyPrtLow   = 9'd32;
   localparam logic [8:0]  KeyPrtHigh  = 9'd96;
   localparam logic [8:0]  KeyQuestion = 9'd63;
   localparam logic [8:0]  KeyAtSign   = 9'd64;
   localparam logic [8:0]  KeyUscore   = 9'd95;

   localparam logic [20:0] MaxScalar   = 21'h10FFFF;

   localparam logic [7:0]  ChEsc    = 8'h1B;
   localparam logic [7:0]  ChDel    = 8'h7F;
   localparam logic [7:0]  ChBs     = 8'h08;
   localparam logic [7:0]  ChCr     = 8'h0D;
   localparam logic [7:0]  ChTab    = 8'h09;
   localparam logic [7:0]  ChNul    = 8'h00;
   localparam logic [7:0]  ChLbrack = 8'h5B;
   localparam logic [7:0]  ChSemi   = 8'h3B;
   localparam logic [7:0]  ChTilde  = 8'h7E;
   localparam logic [7:0]  ChZero   = 8'h30;
   localparam logic [7:0]  ChOne    = 8'h31;
   localparam logic [7:0]  ChTwo    = 8'h32;
   localparam logic [7:0]  ChThree  = 8'h33;
   localparam logic [7:0]  ChFour   = 8'h34;
   localparam logic [7:0]  ChFive   = 8'h35;
   localparam logic [7:0]  ChSix    = 8'h36;
   localparam logic [7:0]  ChSeven  = 8'h37;
   localparam logic [7:0]  ChEight  = 8'h38;
   localparam logic [7:0]  ChNine   = 8'h39;
   localparam logic [7:0]  ChUpA    = 8'h41;
   localparam logic [7:0]  ChUpB    = 8'h42;
   localparam logic [7:0]  ChUpC    = 8'h43;
   localparam logic [7:0]  ChUpD    = 8'h44;
   localparam logic [7:0]  ChUpF    = 8'h46;
   localparam logic [7:0]  ChUpH    = 8'h48;
   localparam logic [7:0]  ChUpO    = 8'h4F;
   localparam logic [7:0]  ChUpP    = 8'h50;
   localparam logic [7:0]  ChUpQ    = 8'h51;
   localparam logic [7:0]  ChUpR    = 8'h52;
   localparam logic [7:0]  ChUpS    = 8'h53;
   localparam logic [7:0]  ChUpZ    = 8'h5A;

   always_comb begin
      logic [tkee_pkg::LenWidth-1:0] k;
      logic                          shift;
      logic                          alt;
      logic                          ctrl;
      logic                          has_mod;
      logic [7:0]                    mod_digit;
      logic                          tilde;
      logic                          letter;
      logic                          use_tens;
      logic [7:0]                    tens;
      logic [7:0]                    ones;
      logic [7:0]                    intro;
      logic [7:0]                    final_ch;
      logic [20:0]                   cp;

      seq       = '0;
      k         = '0;
      shift     = req.modifiers[0];
      alt       = req.modifiers[1];
      ctrl      = req.modifiers[2];
      has_mod   = (req.modifiers != 3'd0);
      mod_digit = ChOne + {5'd0, req.modifiers};
      tilde     = 1'b0;
      letter    = 1'b0;
      use_tens  = 1'b0;
      tens      = ChOne;
      ones      = ChZero;
      intro     = ChLbrack;
      final_ch  = ChUpA;
      cp        = req.codepoint;

      if (req.mode == ModeChar) begin
         if (cp != 21'd0 && cp <= MaxScalar) begin
            if (alt) begin
               seq.seq_bytes[k] = ChEsc;
               k = k + 3'd1;
            end
            if (cp < 21'h80) begin
               seq.seq_bytes[k] = cp[7:0];
               k = k + 3'd1;
            end else if (cp < 21'h800) begin
               seq.seq_bytes[k] = {3'b110, cp[10:6]};
               seq.seq_bytes[k + 3'd1] = {2'b10, cp[5:0]};
               k = k + 3'd2;
            end else if (cp < 21'h10000) begin
               seq.seq_bytes[k] = {4'b1110, cp[15:12]};
               seq.seq_bytes[k + 3'd1] = {2'b10, cp[11:6]};
               seq.seq_bytes[k + 3'd2] = {2'b10, cp[5:0]};
               k = k + 3'd3;
            end else begin
               seq.seq_bytes[k] = {5'b11110, cp[20:18]};
               seq.seq_bytes[k + 3'd1] = {2'b10, cp[17:12]};
               seq.seq_bytes[k + 3'd2] = {2'b10, cp[11:6]};
               seq.seq_bytes[k + 3'd3] = {2'b10, cp[5:0]};
               k = k + 3'd4;
            end
         end
      end else if (req.mode == ModeKeyDown) begin
         unique case (req.key_code)
            KeyEscape: begin
               if (alt) begin
                  seq.seq_bytes[k] = ChEsc;
                  k = k + 3'd1;
               end
               seq.seq_bytes[k] = ChEsc;
               k = k + 3'd1;
            end
            KeyEnter, KeyKpEnter: begin
               if (alt) begin
                  seq.seq_bytes[k] = ChEsc;
                  k = k + 3'd1;
               end
               seq.seq_bytes[k] = ChCr;
               k = k + 3'd1;
            end
            KeyTab: begin
               // Shift-Tab is back-tab regardless of the other modifiers.
               if (shift) begin
                  seq.seq_bytes[0] = ChEsc;
                  seq.seq_bytes[1] = ChLbrack;
                  seq.seq_bytes[2] = ChUpZ;
                  k = 3'd3;
               end else begin
                  if (alt) begin
                     seq.seq_bytes[k] = ChEsc;
                     k = k + 3'd1;
                  end
                  seq.seq_bytes[k] = ChTab;
                  k = k + 3'd1;
               end
            end
            KeyBackspc: begin
               if (alt) begin
                  seq.seq_bytes[k] = ChEsc;
                  k = k + 3'd1;
               end
               seq.seq_bytes[k] = ctrl ? ChBs : ChDel;
               k = k + 3'd1;
            end
            KeyInsert: begin
               tilde = 1'b1;
               ones  = ChTwo;
            end
            KeyDelete: begin
               tilde = 1'b1;
               ones  = ChThree;
            end
            KeyPageUp: begin
               tilde = 1'b1;
               ones  = ChFive;
            end
            KeyPageDown: begin
               tilde = 1'b1;
               ones  = ChSix;
            end
            KeyRight: begin
               letter   = 1'b1;
               final_ch = ChUpC;
            end
            KeyLeft: begin
               letter   = 1'b1;
               final_ch = ChUpD;
            end
            KeyDown: begin
               letter   = 1'b1;
               final_ch = ChUpB;
            end
            KeyUp: begin
               letter   = 1'b1;
               final_ch = ChUpA;
            end
            KeyHome: begin
               letter   = 1'b1;
               final_ch = ChUpH;
            end
            KeyEnd: begin
               letter   = 1'b1;
               final_ch = ChUpF;
            end
            KeyF1: begin
               letter   = 1'b1;
               intro    = ChUpO;
               final_ch = ChUpP;
            end
            KeyF2: begin
               letter   = 1'b1;
               intro    = ChUpO;
               final_ch = ChUpQ;
            end
            KeyF3: begin
               letter   = 1'b1;
               intro    = ChUpO;
               final_ch = ChUpR;
            end
            KeyF4: begin
               letter   = 1'b1;
               intro    = ChUpO;
               final_ch = ChUpS;
            end
            KeyF5: begin
               tilde    = 1'b1;
               use_tens = 1'b1;
               ones     = ChFive;
            end
            KeyF6: begin
               tilde    = 1'b1;
               use_tens = 1'b1;
               ones     = ChSeven;
            end
            KeyF7: begin
               tilde    = 1'b1;
               use_tens = 1'b1;
               ones     = ChEight;
            end
            KeyF8: begin
               tilde    = 1'b1;
               use_tens = 1'b1;
               ones     = ChNine;
            end
            KeyF9: begin
               tilde    = 1'b1;
               use_tens = 1'b1;
               tens     = ChTwo;
               ones     = ChZero;
            end
            KeyF10: begin
               tilde    = 1'b1;
               use_tens = 1'b1;
               tens     = ChTwo;
               ones     = ChOne;
            end
            KeyF11: begin
               tilde    = 1'b1;
               use_tens = 1'b1;
               tens     = ChTwo;
               ones     = ChThree;
            end
            KeyF12: begin
               tilde    = 1'b1;
               use_tens = 1'b1;
               tens     = ChTwo;
               ones     = ChFour;
            end
            default: begin
               // Ctrl folds key codes 64 to 95, '?' and space onto control bytes; other printable codes give nothing.
               if (ctrl && req.key_code >= KeyPrtLow && req.key_code <= KeyPrtHigh) begin
                  if (req.key_code >= KeyAtSign && req.key_code <= KeyUscore) begin
                     if (alt) begin
                        seq.seq_bytes[k] = ChEsc;
                        k = k + 3'd1;
                     end
                     seq.seq_bytes[k] = {3'd0, req.key_code[4:0]};
                     k = k + 3'd1;
                  end else if (req.key_code == KeyQuestion) begin
                     if (alt) begin
                        seq.seq_bytes[k] = ChEsc;
                        k = k + 3'd1;
                     end
                     seq.seq_bytes[k] = ChDel;
                     k = k + 3'd1;
                  end else if (req.key_code == KeyPrtLow) begin
                     if (alt) begin
                        seq.seq_bytes[k] = ChEsc;
                        k = k + 3'd1;
                     end
                     seq.seq_bytes[k] = ChNul;
                     k = k + 3'd1;
                  end
               end
            end
         endcase

         if (tilde) begin
            seq.seq_bytes[0] = ChEsc;
            seq.seq_bytes[1] = ChLbrack;
            k = 3'd2;
            if (use_tens) begin
               seq.seq_bytes[k] = tens;
               k = k + 3'd1;
            end
            seq.seq_bytes[k] = ones;
            k = k + 3'd1;
            if (has_mod) begin
               seq.seq_bytes[k] = ChSemi;
               seq.seq_bytes[k + 3'd1] = mod_digit;
               k = k + 3'd2;
            end
            seq.seq_bytes[k] = ChTilde;
            k = k + 3'd1;
         end

         if (letter) begin
            seq.seq_bytes[0] = ChEsc;
            if (has_mod) begin
               seq.seq_bytes[1] = ChLbrack;
               seq.seq_bytes[2] = ChOne;
               seq.seq_bytes[3] = ChSemi;
               seq.seq_bytes[4] = mod_digit;
               seq.seq_bytes[5] = final_ch;
               k = 3'd6;
            end else begin
               seq.seq_bytes[1] = intro;
               seq.seq_bytes[2] = final_ch;
               k = 3'd3;
            end
         end
      end

      seq.len = k;
   end

   assign req.ready = !q_status.full;
   // Events that produce no bytes are accepted and dropped here.
   assign push = req.valid && !q_status.full && (seq.len != '0);

endmodule

// ===== hw/rtl/tkee_queue.sv =====
// Short FIFO of byte sequence descriptors between front and back end.
// Depends on tkee_pkg.
module tkee_queue #(
   parameter int Depth = 4
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  tkee_pkg::seq_type           push_data,
   input  logic                        pop,
   output tkee_pkg::seq_type           pop_data,
   output tkee_pkg::queue_status_type  status
);

   localparam int PtrWidth = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntWidth = $clog2(Depth + 1);

   tkee_pkg::seq_type   entry_ff [Depth];
   logic [PtrWidth-1:0] wr_ptr_ff;
   logic [PtrWidth-1:0] wr_ptr_in;
   logic [PtrWidth-1:0] rd_ptr_ff;
   logic [PtrWidth-1:0] rd_ptr_in;
   logic [CntWidth-1:0] count_ff;
   logic [CntWidth-1:0] count_in;
   logic                do_push;
   logic                do_pop;

   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == CntWidth'(Depth));
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign pop_data     = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrWidth'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrWidth'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== hw/rtl/tkee_back.sv =====
// Back end: takes descriptors from the queue and sends one byte per word.
// Depends on tkee_pkg and tkee_rsp_if; fed by tkee_queue.
module tkee_back (
   input  logic                       clock,
   input  logic                       reset,
   input  tkee_pkg::queue_status_type q_status,
   input  tkee_pkg::seq_type          q_data,
   output logic                       pop,
   tkee_rsp_if.source                 rsp
);

   tkee_pkg::seq_type             cur_ff;
   tkee_pkg::seq_type             cur_in;
   logic [tkee_pkg::LenWidth-1:0] idx_ff;
   logic [tkee_pkg::LenWidth-1:0] idx_in;
   logic                          busy_ff;
   logic                          busy_in;
   logic                          rsp_valid_ff;
   logic                          rsp_valid_in;
   logic [7:0]                    rsp_byte_ff;
   logic [7:0]                    rsp_byte_in;
   logic                          rsp_last_ff;
   logic                          rsp_last_in;
   logic                          advance;
   logic                          emit;
   logic                          cur_last;

   // The output register moves when it is empty or being taken.
   assign advance  = !rsp_valid_ff || rsp.ready;
   assign emit     = busy_ff && advance;
   assign cur_last = (idx_ff == cur_ff.len - 1'b1);
   // Load the next sequence in the same cycle the final byte leaves.
   assign pop      = !q_status.empty && (!busy_ff || (emit && cur_last));

   always_comb begin
      cur_in       = cur_ff;
      idx_in       = idx_ff;
      busy_in      = busy_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      if (advance) begin
         rsp_valid_in = emit;
      end
      if (emit) begin
         rsp_byte_in = cur_ff.seq_bytes[idx_ff];
         rsp_last_in = cur_last;
      end
      if (pop) begin
         cur_in  = q_data;
         idx_in  = '0;
         busy_in = 1'b1;
      end else if (emit && cur_last) begin
         busy_in = 1'b0;
      end else if (emit) begin
         idx_in = idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      idx_ff      <= idx_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp.valid    = rsp_valid_ff;
   assign rsp.out_byte = rsp_byte_ff;
   assign rsp.last     = rsp_last_ff;

endmodule

// ===== hw/rtl/tkee_checker.sv =====
// Port-level checks for the terminal key event encoder, bound to the top.
// Depends on terminal_key_event_encoder and its channel interfaces.
module tkee_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_last
);

   // A stalled output word keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte) && $stable(rsp_last))
      else $error("rsp word changed while stalled");

   // Reset empties the output register.
   a_reset_rsp: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

   // Reset empties the queue, so the input side is ready right after it.
   a_reset_ready: assert property (@(posedge clock)
      reset |=> req_ready)
      else $error("req not ready after reset");

   // Bytes of one sequence leave back to back once a byte other than the last is taken.
   a_no_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=> rsp_valid)
      else $error("gap inside a byte sequence");

endmodule

bind terminal_key_event_encoder tkee_checker u_tkee_checker (
   .clock        (clock),
   .reset        (reset),
   .req_ready    (req_ch.ready),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .rsp_out_byte (rsp_ch.out_byte),
   .rsp_last     (rsp_ch.last)
);

// ===== tb/terminal_key_event_encoder_tb.sv =====
// Self-checking testbench for terminal_key_event_encoder: keyboard events in, bytes out.
// It predicts each event's byte sequence and checks it in directed, pressure and random phases.
// Depends on tkee_pkg, tkee_if and the encoder RTL.
module terminal_key_event_encoder_tb;

   typedef enum logic [1:0] {
      MODE_CHAR      = 2'd0,
      MODE_KEY_PRESS = 2'd1,
      MODE_KEY_UP    = 2'd2,
      MODE_UNKNOWN   = 2'd3
   } event_mode_type;

   localparam logic [2:0] MOD_NONE  = 3'b000;
   localparam logic [2:0] MOD_SHIFT = 3'b001;
   localparam logic [2:0] MOD_ALT   = 3'b010;
   localparam logic [2:0] MOD_CTRL  = 3'b100;
   localparam logic [2:0] MOD_ALL   = 3'b111;

   localparam logic [8:0] KEY_SPACE      = 9'd32;
   localparam logic [8:0] KEY_QUESTION   = 9'd63;
   localparam logic [8:0] KEY_FOLD_LO    = 9'd64;
   localparam logic [8:0] KEY_LETTER_A   = 9'd65;
   localparam logic [8:0] KEY_BRACKET    = 9'd91;
   localparam logic [8:0] KEY_FOLD_HI    = 9'd95;
   localparam logic [8:0] KEY_PRINT_HI   = 9'd96;
   localparam logic [8:0] KEY_ESCAPE     = 9'd256;
   localparam logic [8:0] KEY_ENTER      = 9'd257;
   localparam logic [8:0] KEY_TAB        = 9'd258;
   localparam logic [8:0] KEY_BACKSPACE  = 9'd259;
   localparam logic [8:0] KEY_INSERT     = 9'd260;
   localparam logic [8:0] KEY_DELETE     = 9'd261;
   localparam logic [8:0] KEY_RIGHT      = 9'd262;
   localparam logic [8:0] KEY_LEFT       = 9'd263;
   localparam logic [8:0] KEY_ARROW_DOWN = 9'd264;
   localparam logic [8:0] KEY_UP         = 9'd265;
   localparam logic [8:0] KEY_PAGE_UP    = 9'd266;
   localparam logic [8:0] KEY_PAGE_DOWN  = 9'd267;
   localparam logic [8:0] KEY_HOME       = 9'd268;
   localparam logic [8:0] KEY_END        = 9'd269;
   localparam logic [8:0] KEY_F1         = 9'd290;
   localparam logic [8:0] KEY_F4         = 9'd293;
   localparam logic [8:0] KEY_F5         = 9'd294;
   localparam logic [8:0] KEY_F12        = 9'd301;
   localparam logic [8:0] KEY_KP_ENTER   = 9'd335;

   localparam tkee_pkg::byte_type BYTE_ESC = 8'h1B;
   localparam tkee_pkg::byte_type BYTE_DEL = 8'h7F;
   localparam tkee_pkg::byte_type BYTE_BS  = 8'h08;
   localparam tkee_pkg::byte_type BYTE_CR  = 8'h0D;
   localparam tkee_pkg::byte_type BYTE_HT  = 8'h09;
   localparam tkee_pkg::byte_type BYTE_NUL = 8'h00;

   localparam logic [20:0] CODEPOINT_MAX = 21'h10FFFF;

   typedef struct {
      tkee_pkg::byte_type out_byte;
      logic               last;
   } term_byte_type;

   logic clock;
   logic reset;

   tkee_req_if req_ch ();
   tkee_rsp_if rsp_ch ();

   terminal_key_event_encoder DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   term_byte_type pending_bytes[$];
   int            error_count;
   int            events_sent;
   int            silent_events;
   int            bytes_checked;
   int            last_event_len;
   int unsigned   hold_off_cycles;
   bit            sender_gaps_on;
   bit            receiver_stalls_on;

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // Works out the byte sequence of one event and queues it; returns its length.
   function automatic int predict_key_event(input logic [1:0] mode, input logic [8:0] key,
                                            input logic [20:0] cp, input logic [2:0] mods);
      tkee_pkg::byte_type seq[$];
      term_byte_type      entry;
      logic               shift;
      logic               alt;
      logic               ctrl;
      int                 param;
      int                 tilde_n;
      bit                 letter_form;
      tkee_pkg::byte_type intro;
      tkee_pkg::byte_type letter;
      shift       = mods[0];
      alt         = mods[1];
      ctrl        = mods[2];
      param       = (mods != MOD_NONE) ? int'(mods) + 1 : 0;
      tilde_n     = 0;
      letter_form = 1'b0;
      intro       = "[";
      letter      = BYTE_NUL;
      case (mode)
         MODE_CHAR: begin
            if (cp != 21'd0 && cp <= CODEPOINT_MAX) begin
               if (alt) seq.push_back(BYTE_ESC);
               if (cp < 21'h80) begin
                  seq.push_back(cp[7:0]);
               end else if (cp < 21'h800) begin
                  seq.push_back({3'b110, cp[10:6]});
                  seq.push_back({2'b10, cp[5:0]});
               end else if (cp < 21'h10000) begin
                  seq.push_back({4'b1110, cp[15:12]});
                  seq.push_back({2'b10, cp[11:6]});
                  seq.push_back({2'b10, cp[5:0]});
               end else begin
                  seq.push_back({5'b11110, cp[20:18]});
                  seq.push_back({2'b10, cp[17:12]});
                  seq.push_back({2'b10, cp[11:6]});
                  seq.push_back({2'b10, cp[5:0]});
               end
            end
         end
         MODE_KEY_PRESS: begin
            case (key)
               KEY_ESCAPE: begin
                  if (alt) seq.push_back(BYTE_ESC);
                  seq.push_back(BYTE_ESC);
               end
               KEY_ENTER, KEY_KP_ENTER: begin
                  if (alt) seq.push_back(BYTE_ESC);
                  seq.push_back(BYTE_CR);
               end
               KEY_TAB: begin
                  // Back-tab wins over every other modifier.
                  if (shift) begin
                     seq.push_back(BYTE_ESC);
                     seq.push_back("[");
                     seq.push_back("Z");
                  end else begin
                     if (alt) seq.push_back(BYTE_ESC);
                     seq.push_back(BYTE_HT);
                  end
               end
               KEY_BACKSPACE: begin
                  if (alt) seq.push_back(BYTE_ESC);
                  seq.push_back(ctrl ? BYTE_BS : BYTE_DEL);
               end
               KEY_INSERT:     tilde_n = 2;
               KEY_DELETE:     tilde_n = 3;
               KEY_PAGE_UP:    tilde_n = 5;
               KEY_PAGE_DOWN:  tilde_n = 6;
               KEY_RIGHT:      begin letter_form = 1'b1; letter = "C"; end
               KEY_LEFT:       begin letter_form = 1'b1; letter = "D"; end
               KEY_ARROW_DOWN: begin letter_form = 1'b1; letter = "B"; end
               KEY_UP:         begin letter_form = 1'b1; letter = "A"; end
               KEY_HOME:       begin letter_form = 1'b1; letter = "H"; end
               KEY_END:        begin letter_form = 1'b1; letter = "F"; end
               default: begin
                  if (key >= KEY_F1 && key <= KEY_F4) begin
                     letter_form = 1'b1;
                     intro       = "O";
                     letter      = tkee_pkg::byte_type'("P" + int'(key - KEY_F1));
                  end else if (key >= KEY_F5 && key <= KEY_F12) begin
                     case (int'(key - KEY_F5))
                        0:       tilde_n = 15;
                        1:       tilde_n = 17;
                        2:       tilde_n = 18;
                        3:       tilde_n = 19;
                        4:       tilde_n = 20;
                        5:       tilde_n = 21;
                        6:       tilde_n = 23;
                        default: tilde_n = 24;
                     endcase
                  end else if (ctrl && key >= KEY_SPACE && key <= KEY_PRINT_HI) begin
                     // Only the fold range, '?' and space give a control byte.
                     if (key >= KEY_FOLD_LO && key <= KEY_FOLD_HI) begin
                        if (alt) seq.push_back(BYTE_ESC);
                        seq.push_back({3'b000, key[4:0]});
                     end else if (key == KEY_QUESTION) begin
                        if (alt) seq.push_back(BYTE_ESC);
                        seq.push_back(BYTE_DEL);
                     end else if (key == KEY_SPACE) begin
                        if (alt) seq.push_back(BYTE_ESC);
                        seq.push_back(BYTE_NUL);
                     end
                  end
               end
            endcase
            if (tilde_n != 0) begin
               seq.push_back(BYTE_ESC);
               seq.push_back("[");
               if (tilde_n >= 10) seq.push_back(tkee_pkg::byte_type'("0" + tilde_n / 10));
               seq.push_back(tkee_pkg::byte_type'("0" + tilde_n % 10));
               if (param != 0) begin
                  seq.push_back(";");
                  seq.push_back(tkee_pkg::byte_type'("0" + param));
               end
               seq.push_back("~");
            end
            if (letter_form) begin
               seq.push_back(BYTE_ESC);
               if (param != 0) begin
                  seq.push_back("[");
                  seq.push_back("1");
                  seq.push_back(";");
                  seq.push_back(tkee_pkg::byte_type'("0" + param));
               end else begin
                  seq.push_back(intro);
               end
               seq.push_back(letter);
            end
         end
         default: ;
      endcase
      foreach (seq[i]) begin
         entry.out_byte = seq[i];
         entry.last     = (i == seq.size() - 1);
         pending_bytes.push_back(entry);
      end
      return seq.size();
   endfunction

   task automatic send_key_event(input logic [1:0] mode, input logic [8:0] key,
                                 input logic [20:0] cp, input logic [2:0] mods);
      int unsigned gap;
      if (sender_gaps_on && $urandom_range(0, 7) == 0) begin
         gap = $urandom_range(1, 13);
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.mode      <= mode;
      req_ch.key_code  <= key;
      req_ch.codepoint <= cp;
      req_ch.modifiers <= mods;
      do @(posedge clock); while (!req_ch.ready);
      last_event_len = predict_key_event(mode, key, cp, mods);
      events_sent++;
      if (last_event_len == 0) silent_events++;
   endtask

   // Lowers valid and holds the input quiet until every predicted byte has arrived.
   task automatic wait_for_drain();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (pending_bytes.size() != 0);
   endtask

   task automatic test_character_events();
      send_key_event(MODE_CHAR, 9'd0, 21'h41, MOD_NONE);
      send_key_event(MODE_CHAR, 9'd0, 21'h0, MOD_ALT);
      send_key_event(MODE_CHAR, 9'd0, CODEPOINT_MAX + 21'd1, MOD_NONE);
      send_key_event(MODE_CHAR, KEY_F12, 21'h7FF, MOD_CTRL);
      send_key_event(MODE_CHAR, 9'd0, 21'hD800, MOD_SHIFT);
      send_key_event(MODE_CHAR, 9'h1FF, 21'hFFFF, MOD_ALL);
      send_key_event(MODE_CHAR, 9'd0, CODEPOINT_MAX, MOD_ALT);
   endtask

   task automatic test_editing_keys();
      send_key_event(MODE_KEY_PRESS, KEY_ESCAPE, 21'd0, MOD_ALT);
      send_key_event(MODE_KEY_PRESS, KEY_KP_ENTER, 21'h1FFFFF, MOD_NONE);
      send_key_event(MODE_KEY_PRESS, KEY_TAB, 21'd0, MOD_SHIFT | MOD_CTRL);
      send_key_event(MODE_KEY_PRESS, KEY_TAB, 21'd0, MOD_ALT);
      send_key_event(MODE_KEY_PRESS, KEY_BACKSPACE, 21'd0, MOD_CTRL | MOD_ALT);
   endtask

   task automatic test_cursor_and_function_keys();
      send_key_event(MODE_KEY_PRESS, KEY_DELETE, 21'd0, MOD_ALL);
      send_key_event(MODE_KEY_PRESS, KEY_PAGE_UP, 21'd0, MOD_NONE);
      send_key_event(MODE_KEY_PRESS, KEY_UP, 21'd0, MOD_SHIFT);
      send_key_event(MODE_KEY_PRESS, KEY_F1, 21'd0, MOD_NONE);
      send_key_event(MODE_KEY_PRESS, KEY_F4, 21'd0, MOD_CTRL);
      send_key_event(MODE_KEY_PRESS, KEY_F12, 21'd0, MOD_ALL);
   endtask

   task automatic test_ctrl_fold();
      send_key_event(MODE_KEY_PRESS, KEY_BRACKET, 21'd0, MOD_CTRL | MOD_ALT);
      send_key_event(MODE_KEY_PRESS, KEY_QUESTION, 21'd0, MOD_CTRL);
      send_key_event(MODE_KEY_PRESS, KEY_SPACE, 21'd0, MOD_CTRL);
      send_key_event(MODE_KEY_PRESS, KEY_PRINT_HI, 21'd0, MOD_CTRL);
      send_key_event(MODE_KEY_PRESS, KEY_LETTER_A, 21'd0, MOD_SHIFT);
   endtask

   task automatic test_silent_events();
      send_key_event(MODE_KEY_UP, KEY_ENTER, 21'h41, MOD_NONE);
      send_key_event(MODE_UNKNOWN, KEY_F5, 21'h41, MOD_ALL);
   endtask

   // The receiver stops for a long stretch while long sequences keep coming, so the
   // descriptor queue fills and the input must stall.
   task automatic test_receiver_hold_off();
      int i;
      hold_off_cycles = 150;
      for (i = 0; i < 16; i++) begin
         send_key_event(MODE_KEY_PRESS, KEY_F5 + 9'(i % 8), 21'd0, 3'($urandom_range(1, 7)));
      end
      wait_for_drain();
   endtask

   // Sends the given number of random events.
   task automatic run_random_events(input int count);
      int          n;
      int unsigned pick;
      logic [1:0]  mode;
      logic [8:0]  key;
      logic [20:0] cp;
      logic [2:0]  mods;
      for (n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         mods = 3'($urandom_range(0, 7));
         cp   = 21'($urandom());
         key  = 9'($urandom_range(0, 511));
         if (pick < 30) begin
            mode = MODE_CHAR;
            case ($urandom_range(0, 4))
               0:       cp = 21'($urandom_range(1, 'h7F));
               1:       cp = 21'($urandom_range('h80, 'h7FF));
               2:       cp = 21'($urandom_range('h800, 'hFFFF));
               3:       cp = 21'($urandom_range('h10000, CODEPOINT_MAX));
               default: ;
            endcase
         end else if (pick < 80) begin
            mode = MODE_KEY_PRESS;
            case ($urandom_range(0, 5))
               0, 1: key = KEY_ESCAPE + 9'($urandom_range(0, KEY_END - KEY_ESCAPE));
               2:    key = KEY_F1 + 9'($urandom_range(0, KEY_F12 - KEY_F1));
               3: begin
                  key = 9'($urandom_range(KEY_SPACE, KEY_PRINT_HI));
                  if ($urandom_range(0, 3) != 0) mods = mods | MOD_CTRL;
               end
               4:       key = KEY_KP_ENTER;
               default: ;
            endcase
         end else if (pick < 90) begin
            mode = MODE_KEY_PRESS;
         end else begin
            mode = ($urandom_range(0, 1) != 0) ? MODE_KEY_UP : MODE_UNKNOWN;
         end
         send_key_event(mode, key, cp, mods);
      end
   endtask

   initial begin : receiver
      int unsigned stall;
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_cycles != 0) begin
            stall           = hold_off_cycles;
            hold_off_cycles = 0;
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
            rsp_ch.ready <= 1'b1;
         end else if (receiver_stalls_on && $urandom_range(0, 7) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clock);
            rsp_ch.ready <= 1'b1;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      term_byte_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         bytes_checked++;
         if (pending_bytes.size() == 0) begin
            $error("unexpected word: out_byte %02h last %0b", rsp_ch.out_byte, rsp_ch.last);
            error_count++;
         end else begin
            want = pending_bytes.pop_front();
            if (rsp_ch.out_byte !== want.out_byte) begin
               $error("out_byte mismatch: expected %02h, got %02h", want.out_byte,
                      rsp_ch.out_byte);
               error_count++;
            end
            if (rsp_ch.last !== want.last) begin
               $error("last mismatch: expected %0b, got %0b", want.last, rsp_ch.last);
               error_count++;
            end
         end
      end
   end

   initial begin
      #20_000_000;
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      error_count        = 0;
      events_sent        = 0;
      silent_events      = 0;
      bytes_checked      = 0;
      last_event_len     = 0;
      hold_off_cycles    = 0;
      sender_gaps_on     = 1'b1;
      receiver_stalls_on = 1'b1;
      reset              = 1'b1;
      req_ch.valid       = 1'b0;
      req_ch.mode        = MODE_KEY_UP;
      req_ch.key_code    = 9'd0;
      req_ch.codepoint   = 21'd0;
      req_ch.modifiers   = MOD_NONE;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_character_events();
      test_editing_keys();
      test_cursor_and_function_keys();
      test_ctrl_fold();
      test_silent_events();
      wait_for_drain();
      test_receiver_hold_off();
      run_random_events(290);
      wait_for_drain();

      // The closing stretch runs at full rate on both sides.
      sender_gaps_on     = 1'b0;
      receiver_stalls_on = 1'b0;
      run_random_events(140);
      wait_for_drain();
      repeat (8) @(posedge clock);

      $display("Sent %0d events (%0d silent) and checked %0d output words.", events_sent,
               silent_events, bytes_checked);
      $display("Covered UTF-8 text, xterm key forms, ctrl folds, back-pressure and idle gaps.");
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
